@@ rtl/core/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the block buffer cache controller.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int DEF_CACHE_ENTRIES = 16;
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 28;
  localparam int SLOT_W = 4;
  localparam int REF_W  = 8;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [1:0] {
    FN_ACQUIRE = 2'd0,
    FN_RELEASE = 2'd1,
    FN_SYNC    = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_HIT   = 3'd0,
    K_FETCH = 3'd1,
    K_WB    = 3'd2,
    K_FULL  = 3'd3,
    K_DONE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_USED = 2'd1,
    ST_MOD  = 2'd2
  } entry_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_SYNC,
    S_RELEASE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  latch;
    logic  lookup;
    logic  scan_clr;
    logic  scan_adv;
    logic  sync_free;
    logic  hit_upd;
    logic  fill;
    logic  rel_upd;
    logic  out_load;
    kind_t out_kind;
  } bbc_cmd_t;

  typedef struct packed {
    logic hit_any;
    logic free_any;
    logic need_wb;
    logic scan_last;
    logic out_free;
    logic req_acq;
  } bbc_sts_t;

endpackage

@@ rtl/core/bbc_datapath.sv @@
// ----------------------------------------------------------------------------
// bbc_datapath
// Slot tables, tag compare, scan counter and the result register.
// ----------------------------------------------------------------------------
module bbc_datapath import bbc_pkg::*; #(
  parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_func,
  input  logic [DEV_W-1:0]  in_dev_id,
  input  logic [BLK_W-1:0]  in_block_num,
  input  logic [SLOT_W-1:0] in_slot_in,
  input  logic              in_dirty,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_kind,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [DEV_W-1:0]  out_dev_out,
  output logic [BLK_W-1:0]  out_block_out,
  output logic              out_last,
  input  bbc_cmd_t          cmd,
  output bbc_sts_t          sts
);

  localparam int IW = $clog2(CACHE_ENTRIES);

  func_t             req_func_r;
  logic [DEV_W-1:0]  req_dev_r;
  logic [BLK_W-1:0]  req_blk_r;
  logic [SLOT_W-1:0] req_slot_r;
  logic              req_dirty_r;

  entry_st_t         status_r  [CACHE_ENTRIES];
  logic [REF_W-1:0]  refcnt_r  [CACHE_ENTRIES];
  logic [DEV_W-1:0]  tag_dev_r [CACHE_ENTRIES];
  logic [BLK_W-1:0]  tag_blk_r [CACHE_ENTRIES];

  logic [CACHE_ENTRIES-1:0] hit_vec_r, hit_vec_nxt;
  logic [CACHE_ENTRIES-1:0] free_vec_r, free_vec_nxt;
  logic [IW-1:0]            hit_idx, free_idx;
  logic [IW-1:0]            scan_r, scan_nxt;

  logic [IW+SLOT_W-1:0]     rel_wide;
  logic [IW-1:0]            rel_idx;
  logic                     rel_ok;

  logic                     out_valid_r, out_valid_nxt;
  kind_t                    out_kind_r;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic [DEV_W-1:0]         out_dev_r, out_dev_nxt;
  logic [BLK_W-1:0]         out_blk_r, out_blk_nxt;
  logic                     out_last_r;
  logic [IW-1:0]            sel_idx;
  logic [IW+SLOT_W-1:0]     sel_wide;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_func_r  <= func_t'(in_func);
      req_dev_r   <= in_dev_id;
      req_blk_r   <= in_block_num;
      req_slot_r  <= in_slot_in;
      req_dirty_r <= in_dirty;
    end
  end

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      free_vec_nxt[i] = (status_r[i] == ST_FREE);
      hit_vec_nxt[i]  = (status_r[i] != ST_FREE) && (tag_dev_r[i] == req_dev_r) &&
                        (tag_blk_r[i] == req_blk_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_vec_r  <= hit_vec_nxt;
      free_vec_r <= free_vec_nxt;
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) hit_idx = IW'(i);
      if (free_vec_r[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    scan_nxt = scan_r;
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.scan_adv) begin
      scan_nxt = scan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  assign rel_wide = {{IW{1'b0}}, req_slot_r};
  assign rel_idx  = rel_wide[IW-1:0];
  assign rel_ok   = 32'(req_slot_r) < 32'(CACHE_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        status_r[i] <= ST_FREE;
        refcnt_r[i] <= '0;
      end
    end else begin
      if (cmd.hit_upd && refcnt_r[hit_idx] != REF_MAX) begin
        refcnt_r[hit_idx] <= refcnt_r[hit_idx] + 1'b1;
      end
      if (cmd.fill) begin
        status_r[free_idx] <= ST_USED;
        refcnt_r[free_idx] <= REF_W'(1);
      end
      if (cmd.sync_free && refcnt_r[scan_r] == '0) begin
        status_r[scan_r] <= ST_FREE;
      end
      if (cmd.rel_upd && rel_ok) begin
        if (refcnt_r[rel_idx] != '0) begin
          refcnt_r[rel_idx] <= refcnt_r[rel_idx] - 1'b1;
        end
        if (req_dirty_r && status_r[rel_idx] != ST_FREE) begin
          status_r[rel_idx] <= ST_MOD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag_dev_r[free_idx] <= req_dev_r;
      tag_blk_r[free_idx] <= req_blk_r;
    end
  end

  assign sel_wide = {{SLOT_W{1'b0}}, sel_idx};

  always_comb begin
    sel_idx     = '0;
    out_dev_nxt = req_dev_r;
    out_blk_nxt = req_blk_r;
    case (cmd.out_kind)
      K_HIT:   sel_idx = hit_idx;
      K_FETCH: sel_idx = free_idx;
      K_WB: begin
        sel_idx     = scan_r;
        out_dev_nxt = tag_dev_r[scan_r];
        out_blk_nxt = tag_blk_r[scan_r];
      end
      K_FULL:  sel_idx = '0;
      default: begin
        out_dev_nxt = '0;
        out_blk_nxt = '0;
      end
    endcase
    if (cmd.out_kind == K_DONE) begin
      out_slot_nxt = (req_func_r == FN_RELEASE) ? req_slot_r : '0;
    end else begin
      out_slot_nxt = sel_wide[SLOT_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_slot_r <= out_slot_nxt;
      out_dev_r  <= out_dev_nxt;
      out_blk_r  <= out_blk_nxt;
      out_last_r <= (cmd.out_kind != K_WB);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_slot_out  = out_slot_r;
  assign out_dev_out   = out_dev_r;
  assign out_block_out = out_blk_r;
  assign out_last      = out_last_r;

  assign sts.hit_any   = |hit_vec_r;
  assign sts.free_any  = |free_vec_r;
  assign sts.need_wb   = (refcnt_r[scan_r] == '0) && (status_r[scan_r] == ST_MOD);
  assign sts.scan_last = (scan_r == IW'(CACHE_ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.req_acq   = (req_func_r == FN_ACQUIRE);

endmodule

@@ rtl/core/bbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbc_ctrl
// Request sequencer: lookup, allocate, sync scan, release and completion.
// ----------------------------------------------------------------------------
module bbc_ctrl import bbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_func,
  output logic     in_ready,
  input  bbc_sts_t sts,
  output bbc_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.out_kind = K_DONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (func_t'(in_func))
            FN_ACQUIRE: begin
              pass_nxt  = 1'b0;
              state_nxt = S_LOOKUP;
            end
            FN_RELEASE: state_nxt = S_RELEASE;
            FN_SYNC: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SYNC;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.hit_any) begin
          cmd.out_kind = K_HIT;
          if (sts.out_free) begin
            cmd.hit_upd  = 1'b1;
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.free_any) begin
          cmd.out_kind = K_FETCH;
          if (sts.out_free) begin
            cmd.fill     = 1'b1;
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (!pass_r) begin
          pass_nxt     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SYNC;
        end else begin
          cmd.out_kind = K_FULL;
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_SYNC: begin
        cmd.out_kind = K_WB;
        if (!sts.need_wb || sts.out_free) begin
          cmd.sync_free = 1'b1;
          cmd.scan_adv  = 1'b1;
          cmd.out_load  = sts.need_wb;
          if (sts.scan_last) begin
            state_nxt = sts.req_acq ? S_LOOKUP : S_DONE;
          end
        end
      end
      S_RELEASE: begin
        cmd.rel_upd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/block_buffer_cache_controller.sv @@
// ----------------------------------------------------------------------------
// block_buffer_cache_controller
// Tag and reference-count controller for a disk block buffer cache.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | func, dev_id, block_num, slot_in, dirty
//  out     | out_valid / out_ready| kind, slot_out, dev_out, block_out, last
//
//  One request at a time. Acquire hit or fetch: accept, tag compare, decide.
//  Release: accept, update, done. Sync: accept, scan of one slot per cycle
//  unless a writeback stalls, done. A syncing acquire then looks up again.
//  Synchronous reset clears slot status and counts at once; no clearing pass.
//  A single result register decouples the sides; the sequencer waits on it
//  only when a new result must be loaded while the previous one is unclaimed.
// ----------------------------------------------------------------------------
module block_buffer_cache_controller import bbc_pkg::*; #(
  parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [DEV_W-1:0]  in_dev_id,
  input  logic [BLK_W-1:0]  in_block_num,
  input  logic [SLOT_W-1:0] in_slot_in,
  input  logic              in_dirty,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [DEV_W-1:0]  out_dev_out,
  output logic [BLK_W-1:0]  out_block_out,
  output logic              out_last
);

  bbc_cmd_t cmd;
  bbc_sts_t sts;

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbc_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_dev_id     (in_dev_id),
    .in_block_num  (in_block_num),
    .in_slot_in    (in_slot_in),
    .in_dirty      (in_dirty),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_slot_out  (out_slot_out),
    .out_dev_out   (out_dev_out),
    .out_block_out (out_block_out),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while a result is pending");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request accepted before the current one finished");

  a_fill_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> sts.free_any && !sts.hit_any)
    else $error("fill issued without a free slot or on a hit");
`endif

endmodule
